>>> rtl/slrec_pkg.sv
// Shared types and constants for the scanline region edge centroid block.
package slrec_pkg;

   localparam int IMAGE_WIDTH  = 640;
   localparam int IMAGE_HEIGHT = 480;

   localparam int PIX_W  = 8;
   localparam int COL_W  = $clog2(IMAGE_WIDTH + 1);
   localparam int ROW_W  = $clog2(IMAGE_HEIGHT);
   localparam int CNT_W  = 10;
   localparam int SUM_W  = 19;
   localparam int FRAC_W = 12;

   localparam int SLOPE_W = 19;
   localparam int ICPT_W  = 25;
   localparam int PROD_W  = SLOPE_W + ROW_W + 1;
   localparam int LINE_W  = PROD_W + 1;

   localparam int NUM_REGIONS = 4;
   localparam int NUM_BOUNDS  = NUM_REGIONS - 1;
   localparam int REGION_W    = $clog2(NUM_REGIONS);
   localparam int BIDX_W      = $clog2(NUM_BOUNDS);
   localparam int STEP_W      = $clog2(SUM_W);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = ICPT_W;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOPE_A     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERCEPT_A = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOPE_B     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERCEPT_B = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOPE_C     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERCEPT_C = 3'd5;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_value;
      logic [COL_W-1:0] pixel_column;
      logic [ROW_W-1:0] row_number;
      logic             end_of_row;
   } req_type;

   typedef struct packed {
      logic [REGION_W-1:0] region_index;
      logic [COL_W-1:0]    point_column;
      logic [ROW_W-1:0]    scan_row;
      logic                last_of_row;
   } rsp_type;

   // One finished row, handed from the accumulating front to the divider.
   typedef struct packed {
      logic [ROW_W-1:0]                    row;
      logic [NUM_REGIONS-1:0][COL_W-1:0]   lo;
      logic [NUM_REGIONS-1:0][CNT_W-1:0]   cnt;
      logic [NUM_REGIONS-1:0][SUM_W-1:0]   sum;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

>>> rtl/slrec_front.sv
// Front end: line registers, bound placement and per-region accumulation.
module slrec_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [slrec_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [slrec_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  slrec_pkg::req_type               req_data,
   output logic                             q_push,
   output slrec_pkg::job_type               q_job,
   input  slrec_pkg::qstat_type             q_stat
);
   import slrec_pkg::*;

   typedef enum logic [2:0] {F_IDLE, F_MUL, F_ADD, F_ACC, F_PUSH} fst_type;

   fst_type st_ff, st_in;
   logic    row_open_ff, row_open_in;
   logic [BIDX_W-1:0] bidx_ff, bidx_in;
   logic [NUM_BOUNDS-1:0][SLOPE_W-1:0] slope_ff, slope_in;
   logic [NUM_BOUNDS-1:0][ICPT_W-1:0]  icpt_ff, icpt_in;
   logic [NUM_BOUNDS-1:0][COL_W-1:0]   bound_ff, bound_in;
   logic [NUM_REGIONS-1:0][CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_REGIONS-1:0][SUM_W-1:0]  sum_ff, sum_in;
   req_type pix_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic    req_accept, acc_en;
   req_type pix;
   logic signed [LINE_W-1:0] line_q12;
   logic [LINE_W-FRAC_W-2:0] line_col;
   logic [COL_W-1:0] bound_val;
   logic [NUM_REGIONS-1:0][COL_W-1:0] lo, hi;

   assign csr_ready  = 1'b1;
   assign req_stall  = (st_ff != F_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign q_push     = (st_ff == F_PUSH) && !q_stat.full;

   always_comb begin
      q_job.row = pix_ff.row_number;
      q_job.lo  = lo;
      q_job.cnt = cnt_ff;
      q_job.sum = sum_ff;
   end

   // Shared multiplier, registered; add, truncate and clamp in the next cycle.
   assign prod_in  = $signed(slope_ff[bidx_ff]) * $signed({1'b0, pix_ff.row_number});
   assign line_q12 = LINE_W'(prod_ff) + LINE_W'($signed(icpt_ff[bidx_ff]));
   assign line_col = line_q12[LINE_W-2:FRAC_W];

   always_comb begin
      if (line_q12[LINE_W-1]) begin
         bound_val = '0;
      end else if (line_col > (LINE_W-FRAC_W-1)'(IMAGE_WIDTH)) begin
         bound_val = COL_W'(IMAGE_WIDTH);
      end else begin
         bound_val = line_col[COL_W-1:0];
      end
   end

   always_comb begin
      lo[0] = '0;
      for (int j = 0; j < NUM_BOUNDS; j++) begin
         lo[j+1] = bound_ff[j];
         hi[j]   = bound_ff[j];
      end
      hi[NUM_REGIONS-1] = COL_W'(IMAGE_WIDTH);
   end

   assign pix    = (st_ff == F_ACC) ? pix_ff : req_data;
   assign acc_en = (st_ff == F_ACC) || (req_accept && row_open_ff);

   always_comb begin
      st_in       = st_ff;
      row_open_in = row_open_ff;
      bidx_in     = bidx_ff;
      slope_in    = slope_ff;
      icpt_in     = icpt_ff;
      bound_in    = bound_ff;
      cnt_in      = cnt_ff;
      sum_in      = sum_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SLOPE_A:     slope_in[0] = csr_wdata[SLOPE_W-1:0];
            CSR_INTERCEPT_A: icpt_in[0]  = csr_wdata;
            CSR_SLOPE_B:     slope_in[1] = csr_wdata[SLOPE_W-1:0];
            CSR_INTERCEPT_B: icpt_in[1]  = csr_wdata;
            CSR_SLOPE_C:     slope_in[2] = csr_wdata[SLOPE_W-1:0];
            CSR_INTERCEPT_C: icpt_in[2]  = csr_wdata;
            default: ;
         endcase
      end

      // Regions may overlap when bounds are out of order; each counts the pixel.
      if (acc_en && (pix.pixel_value != '0)) begin
         for (int j = 0; j < NUM_REGIONS; j++) begin
            if ((pix.pixel_column >= lo[j]) && (pix.pixel_column < hi[j])) begin
               cnt_in[j] = cnt_ff[j] + CNT_W'(1);
               sum_in[j] = sum_ff[j] + SUM_W'(pix.pixel_column - lo[j]);
            end
         end
      end

      unique case (st_ff)
         F_IDLE: begin
            if (req_accept) begin
               if (!row_open_ff) begin
                  bidx_in     = '0;
                  row_open_in = 1'b1;
                  st_in       = F_MUL;
               end else if (req_data.end_of_row) begin
                  st_in = F_PUSH;
               end
            end
         end
         F_MUL: st_in = F_ADD;
         F_ADD: begin
            bound_in[bidx_ff] = bound_val;
            if (bidx_ff == BIDX_W'(NUM_BOUNDS - 1)) begin
               st_in = F_ACC;
            end else begin
               bidx_in = bidx_ff + BIDX_W'(1);
               st_in   = F_MUL;
            end
         end
         F_ACC: st_in = pix_ff.end_of_row ? F_PUSH : F_IDLE;
         F_PUSH: begin
            if (!q_stat.full) begin
               cnt_in      = '0;
               sum_in      = '0;
               row_open_in = 1'b0;
               st_in       = F_IDLE;
            end
         end
         default: st_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= F_IDLE;
         row_open_ff <= 1'b0;
         bidx_ff     <= '0;
         slope_ff    <= '0;
         icpt_ff     <= '0;
         bound_ff    <= '0;
         cnt_ff      <= '0;
         sum_ff      <= '0;
      end else begin
         st_ff       <= st_in;
         row_open_ff <= row_open_in;
         bidx_ff     <= bidx_in;
         slope_ff    <= slope_in;
         icpt_ff     <= icpt_in;
         bound_ff    <= bound_in;
         cnt_ff      <= cnt_in;
         sum_ff      <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pix_ff <= req_data;
      end
      prod_ff <= prod_in;
   end

`ifndef ASSERT_OFF
   a_first_pixel_holds: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !row_open_ff) |=> req_stall)
      else $error("front accepted a pixel while placing bounds");
   a_push_closes_row: assert property (@(posedge clock) disable iff (reset)
      q_push |=> !row_open_ff)
      else $error("row still open after its job was queued");
   a_bound_in_range: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_job.lo[NUM_REGIONS-1] <= COL_W'(IMAGE_WIDTH)))
      else $error("region bound beyond image width");
`endif

endmodule

>>> rtl/slrec_queue.sv
// Short queue of finished-row jobs between the front and back ends.
module slrec_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  slrec_pkg::job_type   push_job,
   input  logic                 pop,
   output slrec_pkg::job_type   head_job,
   output slrec_pkg::qstat_type stat
);
   import slrec_pkg::*;

   job_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;

   assign stat.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign head_job   = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + QPTR_W'(1);
      end
      priority if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full)
      else $error("push into full row queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty)
      else $error("pop from empty row queue");
`endif

endmodule

>>> rtl/slrec_back.sv
// Back end: per-region restoring divider and result output register.
module slrec_back (
   input  logic                 clock,
   input  logic                 reset,
   input  slrec_pkg::job_type   head_job,
   input  slrec_pkg::qstat_type q_stat,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output slrec_pkg::rsp_type   rsp_data
);
   import slrec_pkg::*;

   typedef enum logic [1:0] {B_IDLE, B_PREP, B_DIV, B_OUT} bst_type;

   bst_type st_ff, st_in;
   logic [REGION_W-1:0] ra_ff, ra_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                zero_ff, zero_in;
   logic                rsp_valid_ff, rsp_valid_in;
   job_type             job_ff;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]    quo_ff, quo_in, dvd_ff, dvd_in;
   rsp_type             rsp_ff, rsp_in;

   logic [CNT_W-1:0] cnt_sel;
   logic [SUM_W-1:0] sum_sel;
   logic [COL_W-1:0] lo_sel;
   logic [CNT_W:0]   rem_sh;
   logic             ge;
   logic             out_load;

   assign cnt_sel  = job_ff.cnt[ra_ff];
   assign sum_sel  = job_ff.sum[ra_ff];
   assign lo_sel   = job_ff.lo[ra_ff];
   assign q_pop    = (st_ff == B_IDLE) && !q_stat.empty;
   assign out_load = (st_ff == B_OUT) && (!rsp_valid_ff || !rsp_stall);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // One quotient bit per cycle; remainder stays below the count.
   assign rem_sh = {rem_ff, dvd_ff[SUM_W-1]};
   assign ge     = (rem_sh >= {1'b0, cnt_sel});

   always_comb begin
      st_in        = st_ff;
      ra_in        = ra_ff;
      step_in      = step_ff;
      zero_in      = zero_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvd_in       = dvd_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (st_ff)
         B_IDLE: begin
            if (!q_stat.empty) begin
               ra_in = '0;
               st_in = B_PREP;
            end
         end
         B_PREP: begin
            rem_in  = '0;
            quo_in  = '0;
            dvd_in  = sum_sel;
            step_in = '0;
            zero_in = (sum_sel == '0) || (cnt_sel == '0);
            st_in   = ((sum_sel == '0) || (cnt_sel == '0)) ? B_OUT : B_DIV;
         end
         B_DIV: begin
            rem_in  = ge ? CNT_W'(rem_sh - {1'b0, cnt_sel}) : rem_sh[CNT_W-1:0];
            quo_in  = {quo_ff[SUM_W-2:0], ge};
            dvd_in  = {dvd_ff[SUM_W-2:0], 1'b0};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               st_in = B_OUT;
            end
         end
         B_OUT: begin
            if (out_load) begin
               rsp_valid_in        = 1'b1;
               rsp_in.region_index = ra_ff;
               rsp_in.point_column = zero_ff ? '0 : lo_sel + quo_ff[COL_W-1:0];
               rsp_in.scan_row     = job_ff.row;
               rsp_in.last_of_row  = (ra_ff == REGION_W'(NUM_REGIONS - 1));
               if (ra_ff == REGION_W'(NUM_REGIONS - 1)) begin
                  st_in = B_IDLE;
               end else begin
                  ra_in = ra_ff + REGION_W'(1);
                  st_in = B_PREP;
               end
            end
         end
         default: st_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= B_IDLE;
         ra_ff        <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         ra_ff        <= ra_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= head_job;
      end
      zero_ff <= zero_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvd_ff  <= dvd_in;
      rsp_ff  <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (st_ff == B_DIV) |-> (cnt_sel != '0))
      else $error("divider running with zero count");
   a_last_is_region3: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last_of_row) |->
         (rsp_ff.region_index == REGION_W'(NUM_REGIONS - 1)))
      else $error("last_of_row on a region other than the rightmost");
`endif

endmodule

>>> rtl/scanline_region_edge_centroid.sv
// Top level: scanline region edge centroid, front end, row queue and divider back end.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_data  (slrec_pkg::req_type)
//   rsp_      out        rsp_valid/rsp_stall  rsp_data  (slrec_pkg::rsp_type)
//   csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// A pixel inside an open row is counted as it is accepted. The first pixel of a row
// stalls the input while the three bounds share one multiplier, each taking a multiply
// and an add step, then the pixel is counted. An end-of-row pixel then hands the row to
// the queue, waiting while it is full. The back end pops a row and runs each region in
// turn through its one restoring divider, while the next row accumulates.
// Reset is synchronous; it clears line registers, counts and both queue ends.
// rsp_stall holds the output register; req_stall is high while the front end is busy.
module scanline_region_edge_centroid (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [slrec_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [slrec_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  slrec_pkg::req_type               req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output slrec_pkg::rsp_type               rsp_data
);
   import slrec_pkg::*;

   logic      q_push, q_pop;
   job_type   push_job, head_job;
   qstat_type q_stat;

   slrec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_job     (push_job),
      .q_stat    (q_stat)
   );

   slrec_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .stat     (q_stat)
   );

   slrec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/sv/scanline_region_edge_centroid_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the scanline region edge centroid block.
module scanline_region_edge_centroid_tb;
   import slrec_pkg::*;

   // Indexes past the last line register; writes to them must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   localparam logic [CSR_DATA_W-1:0] SLOPE_MAX = CSR_DATA_W'(262143);
   localparam logic [CSR_DATA_W-1:0] SLOPE_MIN = CSR_DATA_W'(-262144);
   localparam logic [CSR_DATA_W-1:0] ICPT_MAX  = CSR_DATA_W'(16777215);
   localparam logic [CSR_DATA_W-1:0] ICPT_MIN  = CSR_DATA_W'(-16777216);

   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 600;
   localparam int SETTLE_CYCLES = 24;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;

   // Predictor state
   logic signed [SLOPE_W-1:0] line_slope     [NUM_BOUNDS];
   logic signed [ICPT_W-1:0]  line_icpt      [NUM_BOUNDS];
   logic [COL_W-1:0]          bound_col      [NUM_BOUNDS];
   logic [CNT_W-1:0]          region_edges   [NUM_REGIONS];
   logic [SUM_W-1:0]          region_offsets [NUM_REGIONS];
   logic                      row_active;
   rsp_type                   pending_points [$];

   int errors_seen   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_request  = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   scanline_region_edge_centroid dut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   function automatic logic [CSR_DATA_W-1:0] q12_cols(input int cols);
      return CSR_DATA_W'(cols * (1 << FRAC_W));
   endfunction

   // trunc(slope*row + intercept) in columns, clamped to the image
   function automatic logic [COL_W-1:0] line_column(input logic signed [SLOPE_W-1:0] slope,
         input logic signed [ICPT_W-1:0] icpt, input logic [ROW_W-1:0] row);
      longint acc;
      acc = (longint'(slope) * longint'(row) + longint'(icpt)) / (1 << FRAC_W);
      if (acc < 0) acc = 0;
      if (acc > IMAGE_WIDTH) acc = IMAGE_WIDTH;
      return COL_W'(acc);
   endfunction

   task automatic track_pixel(input req_type px);
      logic [COL_W-1:0] lo [NUM_REGIONS];
      logic [COL_W-1:0] hi [NUM_REGIONS];
      logic [SUM_W-1:0] mean;
      rsp_type          pt;
      if (!row_active) begin
         for (int j = 0; j < NUM_BOUNDS; j++)
            bound_col[j] = line_column(line_slope[j], line_icpt[j], px.row_number);
         row_active = 1'b1;
      end
      lo[0] = '0;
      for (int j = 0; j < NUM_BOUNDS; j++) begin
         hi[j]     = bound_col[j];
         lo[j + 1] = bound_col[j];
      end
      hi[NUM_REGIONS - 1] = COL_W'(IMAGE_WIDTH);
      // Overlapping regions each count the same pixel.
      if (px.pixel_value != 0) begin
         for (int j = 0; j < NUM_REGIONS; j++) begin
            if (px.pixel_column >= lo[j] && px.pixel_column < hi[j]) begin
               region_edges[j]   = region_edges[j] + 1'b1;
               region_offsets[j] = region_offsets[j] + (px.pixel_column - lo[j]);
            end
         end
      end
      if (px.end_of_row) begin
         for (int j = 0; j < NUM_REGIONS; j++) begin
            pt.region_index = REGION_W'(j);
            pt.point_column = '0;
            if (region_offsets[j] != 0 && region_edges[j] != 0) begin
               mean            = region_offsets[j] / region_edges[j];
               pt.point_column = lo[j] + mean[COL_W-1:0];
            end
            pt.scan_row    = px.row_number;
            pt.last_of_row = (j == NUM_REGIONS - 1);
            pending_points.push_back(pt);
            region_edges[j]   = '0;
            region_offsets[j] = '0;
         end
         row_active = 1'b0;
      end
   endtask

   task automatic send_pixel(input req_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data  <= px;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      track_pixel(px);
   endtask

   function automatic req_type make_pixel(input int value, input int column, input int row,
         input bit last);
      req_type px;
      px.pixel_value  = PIX_W'(value);
      px.pixel_column = COL_W'(column);
      px.row_number   = ROW_W'(row);
      px.end_of_row   = last;
      return px;
   endfunction

   // Leaves csr_valid high so back-to-back writes need no second assignment in one step.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SLOPE_A:     line_slope[0] = data[SLOPE_W-1:0];
         CSR_INTERCEPT_A: line_icpt[0]  = data[ICPT_W-1:0];
         CSR_SLOPE_B:     line_slope[1] = data[SLOPE_W-1:0];
         CSR_INTERCEPT_B: line_icpt[1]  = data[ICPT_W-1:0];
         CSR_SLOPE_C:     line_slope[2] = data[SLOPE_W-1:0];
         CSR_INTERCEPT_C: line_icpt[2]  = data[ICPT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_lines(input logic [CSR_DATA_W-1:0] sa, ia, sb, ib, sc, ic);
      write_csr(CSR_SLOPE_A, sa);
      write_csr(CSR_INTERCEPT_A, ia);
      write_csr(CSR_SLOPE_B, sb);
      write_csr(CSR_INTERCEPT_B, ib);
      write_csr(CSR_SLOPE_C, sc);
      write_csr(CSR_INTERCEPT_C, ic);
      csr_valid <= 1'b0;
   endtask

   task automatic load_random_lines();
      logic [CSR_DATA_W-1:0] slope [NUM_BOUNDS];
      logic [CSR_DATA_W-1:0] icpt  [NUM_BOUNDS];
      bit                    wild;
      wild = ($urandom_range(3) == 0);
      for (int j = 0; j < NUM_BOUNDS; j++) begin
         if (wild) begin
            slope[j] = CSR_DATA_W'($urandom());
            icpt[j]  = CSR_DATA_W'($urandom());
         end else begin
            // Roughly ordered lines that drift and may cross over the image height.
            slope[j] = CSR_DATA_W'(int'($urandom_range(4095)) - 2048);
            icpt[j]  = q12_cols(int'($urandom_range(200)) + 160 * j)
                       + CSR_DATA_W'($urandom_range(4095));
         end
      end
      load_lines(slope[0], icpt[0], slope[1], icpt[1], slope[2], icpt[2]);
   endtask

   task automatic send_random_row(input int length, input bit noisy);
      req_type          px;
      logic [ROW_W-1:0] row;
      row = ($urandom_range(9) == 0) ? ROW_W'($urandom_range(511, 480))
                                     : ROW_W'($urandom_range(479));
      for (int i = 0; i < length; i++) begin
         px.pixel_value  = ($urandom_range(1) == 0) ? '0 : PIX_W'($urandom_range(255, 1));
         px.pixel_column = noisy ? COL_W'($urandom()) : COL_W'($urandom_range(IMAGE_WIDTH - 1));
         px.row_number   = (noisy && $urandom_range(3) == 0) ? ROW_W'($urandom()) : row;
         px.end_of_row   = (i == length - 1);
         send_pixel(px);
      end
   endtask

   // Drop valid, wait for every expected point, then let the front end go quiet.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_default_lines();
      wait_idle();
      send_pixel(make_pixel(1, 0, 0, 0));
      send_pixel(make_pixel(255, 639, 0, 0));
      send_pixel(make_pixel(0, 5, 0, 0));
      send_pixel(make_pixel(0, 10, 0, 1));
   endtask

   task automatic test_line_extremes();
      wait_idle();
      // Bounds land at 640, 0 and 320: misordered, with overlapping regions.
      load_lines(SLOPE_MAX, ICPT_MAX, SLOPE_MIN, ICPT_MIN, '0, q12_cols(320) + 4095);
      send_pixel(make_pixel(1, 0, 0, 0));
      send_pixel(make_pixel(255, 319, 0, 0));
      send_pixel(make_pixel(128, 320, 0, 0));
      send_pixel(make_pixel(2, 639, 0, 0));
      send_pixel(make_pixel(255, 640, 0, 0));
      send_pixel(make_pixel(7, 1023, 0, 1));
      send_pixel(make_pixel(255, 100, 511, 1));
      wait_idle();
      // Upper data bits of a slope write are ignored; spare indexes hold nothing.
      write_csr(CSR_SPARE_6, '1);
      write_csr(CSR_SPARE_7, '1);
      write_csr(CSR_SLOPE_C, '1);
      csr_valid <= 1'b0;
      send_pixel(make_pixel(1, 320, 479, 0));
      send_pixel(make_pixel(1, 321, 479, 1));
   endtask

   task automatic test_row_change();
      wait_idle();
      load_lines(q12_cols(1), '0, q12_cols(2), '0, '0, q12_cols(600));
      // Bounds come from the first pixel's row; scan_row from the last.
      send_pixel(make_pixel(9, 150, 100, 0));
      send_pixel(make_pixel(9, 50, 200, 0));
      send_pixel(make_pixel(9, 250, 300, 1));
   endtask

   task automatic test_single_pixel_rows();
      send_pixel(make_pixel(200, 450, 42, 1));
      send_pixel(make_pixel(0, 10, 43, 1));
   endtask

   task automatic test_random_traffic(input int send_pct, input int stall_pct_in,
         input int quota);
      int sent;
      int length;
      wait_idle();
      send_idle_pct = send_pct;
      stall_pct     = stall_pct_in;
      load_random_lines();
      sent = 0;
      while (sent < quota) begin
         length = ($urandom_range(7) == 0) ? $urandom_range(40, 16) : $urandom_range(8, 1);
         send_random_row(length, $urandom_range(6) == 0);
         sent += length;
      end
   endtask

   task automatic test_output_backpressure();
      wait_idle();
      send_idle_pct = 0;
      stall_pct     = 0;
      load_random_lines();
      hold_request = HOLD_CYCLES;
      for (int i = 0; i < 30; i++) send_random_row(2, 1'b0);
   endtask

   // Receiver: random stall, or a long counted hold-off on request.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin : check_point
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            $error("point with nothing expected: %p", rsp_data);
            errors_seen++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_data.region_index !== want.region_index) begin
               $error("region_index expected %0d actual %0d", want.region_index,
                      rsp_data.region_index);
               errors_seen++;
            end
            if (rsp_data.point_column !== want.point_column) begin
               $error("point_column expected %0d actual %0d", want.point_column,
                      rsp_data.point_column);
               errors_seen++;
            end
            if (rsp_data.scan_row !== want.scan_row) begin
               $error("scan_row expected %0d actual %0d", want.scan_row, rsp_data.scan_row);
               errors_seen++;
            end
            if (rsp_data.last_of_row !== want.last_of_row) begin
               $error("last_of_row expected %0d actual %0d", want.last_of_row,
                      rsp_data.last_of_row);
               errors_seen++;
            end
         end
      end
   end

   // Watchdog: count cycles in which no channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL scanline_region_edge_centroid");
         $finish;
      end
   end

   initial begin
      for (int j = 0; j < NUM_BOUNDS; j++) begin
         line_slope[j] = '0;
         line_icpt[j]  = '0;
         bound_col[j]  = '0;
      end
      for (int j = 0; j < NUM_REGIONS; j++) begin
         region_edges[j]   = '0;
         region_offsets[j] = '0;
      end
      row_active = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_default_lines();
      test_line_extremes();
      test_row_change();
      test_single_pixel_rows();
      test_random_traffic(0, 0, 60);
      test_random_traffic(69, 0, 60);
      test_random_traffic(0, 69, 60);
      test_random_traffic(28, 28, 60);
      test_output_backpressure();

      wait_idle();
      if (errors_seen == 0)
         $display("PASS scanline_region_edge_centroid");
      else
         $display("FAIL scanline_region_edge_centroid");
      $finish;
   end

endmodule
